// ===== hw/rtl/kf2_pkg.sv =====
// Shared types, constants and fixed-point helpers of the two-state Kalman filter.
package kf2_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int ACC_W     = DW + 3;
	localparam int DVD_W     = DW + FRAC_BITS;
	localparam int DCNT_W    = $clog2(DVD_W + 1);
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 5;

	localparam logic [STEP_W-1:0] STEP_PRE_LAST = STEP_W'(18);
	localparam logic [STEP_W-1:0] STEP_LAST     = STEP_W'(25);

	localparam logic OP_MEAS  = 1'b0;
	localparam logic OP_RESET = 1'b1;

	localparam logic signed [DW-1:0] FX_ONE = DW'(1) << FRAC_BITS;
	localparam logic signed [DW-1:0] S_MAX  = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] S_MIN  = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [4:0] {
		SRC_ZERO, SRC_ONE,
		SRC_QN0, SRC_QN1, SRC_QN2, SRC_QN3,
		SRC_P0, SRC_P1, SRC_P2, SRC_P3,
		SRC_PP0, SRC_PP1, SRC_PP2, SRC_PP3,
		SRC_U0, SRC_U1, SRC_V0, SRC_V1,
		SRC_K0, SRC_K1, SRC_TM, SRC_E,
		SRC_C0, SRC_C1, SRC_X0, SRC_X1, SRC_Z, SRC_R
	} src_t;

	typedef enum logic [4:0] {
		DST_NONE,
		DST_PP0, DST_PP1, DST_PP2, DST_PP3,
		DST_U0, DST_U1, DST_V0, DST_V1, DST_S, DST_TM, DST_E,
		DST_X0, DST_X1, DST_P0, DST_P1, DST_P2, DST_P3
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		logic init_en;
		src_t init_src;
		logic neg;
		dst_t dst;
	} micro_t;

	typedef struct packed {
		logic   capture;
		logic   clear_state;
		logic   set_derr;
		logic   div_start;
		logic   finish;
		micro_t uop;
	} cmd_t;

	typedef struct packed {
		logic s_zero;
		logic div_done;
	} sts_t;

	function automatic micro_t uop(input src_t a, input src_t b, input logic ien,
			input src_t isrc, input logic neg, input dst_t dst);
		micro_t m;
		m.a = a;
		m.b = b;
		m.init_en = ien;
		m.init_src = isrc;
		m.neg = neg;
		m.dst = dst;
		return m;
	endfunction

	localparam micro_t UOP_NOP = '{SRC_ZERO, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0, DST_NONE};

	// Operation sequence. A result written by one step may be read two steps later.
	function automatic micro_t ucode(input logic [STEP_W-1:0] step);
		micro_t m;
		unique case (step)
			5'd0:  m = uop(SRC_QN0, SRC_ONE, 1'b1, SRC_P0, 1'b0, DST_PP0);
			5'd1:  m = uop(SRC_QN1, SRC_ONE, 1'b1, SRC_P1, 1'b0, DST_PP1);
			5'd2:  m = uop(SRC_QN2, SRC_ONE, 1'b1, SRC_P2, 1'b0, DST_PP2);
			5'd3:  m = uop(SRC_QN3, SRC_ONE, 1'b1, SRC_P3, 1'b0, DST_PP3);
			5'd5:  m = uop(SRC_C0, SRC_PP0, 1'b1, SRC_ZERO, 1'b0, DST_NONE);
			5'd6:  m = uop(SRC_C1, SRC_PP2, 1'b0, SRC_ZERO, 1'b0, DST_U0);
			5'd7:  m = uop(SRC_C0, SRC_PP1, 1'b1, SRC_ZERO, 1'b0, DST_NONE);
			5'd8:  m = uop(SRC_C1, SRC_PP3, 1'b0, SRC_ZERO, 1'b0, DST_U1);
			5'd9:  m = uop(SRC_PP0, SRC_C0, 1'b1, SRC_ZERO, 1'b0, DST_NONE);
			5'd10: m = uop(SRC_PP1, SRC_C1, 1'b0, SRC_ZERO, 1'b0, DST_V0);
			5'd11: m = uop(SRC_PP2, SRC_C0, 1'b1, SRC_ZERO, 1'b0, DST_NONE);
			5'd12: m = uop(SRC_PP3, SRC_C1, 1'b0, SRC_ZERO, 1'b0, DST_V1);
			5'd13: m = uop(SRC_U0, SRC_C0, 1'b1, SRC_R, 1'b0, DST_NONE);
			5'd14: m = uop(SRC_U1, SRC_C1, 1'b0, SRC_ZERO, 1'b0, DST_S);
			5'd15: m = uop(SRC_C0, SRC_X0, 1'b1, SRC_ZERO, 1'b0, DST_NONE);
			5'd16: m = uop(SRC_C1, SRC_X1, 1'b0, SRC_ZERO, 1'b0, DST_TM);
			5'd18: m = uop(SRC_TM, SRC_ONE, 1'b1, SRC_Z, 1'b1, DST_E);
			5'd19: m = uop(SRC_K0, SRC_E, 1'b1, SRC_X0, 1'b0, DST_X0);
			5'd20: m = uop(SRC_K1, SRC_E, 1'b1, SRC_X1, 1'b0, DST_X1);
			5'd21: m = uop(SRC_K0, SRC_U0, 1'b1, SRC_PP0, 1'b1, DST_P0);
			5'd22: m = uop(SRC_K0, SRC_U1, 1'b1, SRC_PP1, 1'b1, DST_P1);
			5'd23: m = uop(SRC_K1, SRC_U0, 1'b1, SRC_PP2, 1'b1, DST_P2);
			5'd24: m = uop(SRC_K1, SRC_U1, 1'b1, SRC_PP3, 1'b1, DST_P3);
			default: m = UOP_NOP;
		endcase
		return m;
	endfunction

	// Floor of a product scaled down by the fraction bits, saturated to one word.
	function automatic logic signed [DW-1:0] sat_prod(input logic signed [2*DW-1:0] p);
		logic signed [2*DW-1:0] sh;
		logic signed [DW-1:0] r;
		sh = p >>> FRAC_BITS;
		if (&sh[2*DW-1:DW-1] || ~|sh[2*DW-1:DW-1]) r = sh[DW-1:0];
		else if (sh[2*DW-1]) r = S_MIN;
		else r = S_MAX;
		return r;
	endfunction

	function automatic logic signed [DW-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
		logic signed [DW-1:0] r;
		if (&a[ACC_W-1:DW-1] || ~|a[ACC_W-1:DW-1]) r = a[DW-1:0];
		else if (a[ACC_W-1]) r = S_MIN;
		else r = S_MAX;
		return r;
	endfunction

endpackage

// ===== hw/rtl/kalman_filter_2state_scalar_update.sv =====
// Top level of the two-state Kalman filter with a scalar measurement update.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  input     | in_valid / in_ready   | opcode, meas_value, meas_variance,
//            |                       | obs_coef_0, obs_coef_1, meas_time
//  output    | out_valid / out_ready | state_est_*, cov_*, pose_valid, prev_est_*,
//            |                       | prev_time, div_error
//  config    | cfg_we                | cfg_index, cfg_data (process noise Q)
//
// A measurement beat runs 19 steps on the one shared multiplier, a variance check,
// the two-lane divider (one quotient bit per cycle over 48 bits), 7 more multiplier
// steps and the finish state, which waits until the output is free. A zero innovation
// variance skips the divider and the later steps and goes straight to finish.
// A reset beat clears estimate, covariance and time mark; arst_n also the Q registers.
// A new beat is taken as soon as the sequencer is idle, even while the last
// result still waits on out_ready; a further result then waits for that one.
module kalman_filter_2state_scalar_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic signed [kf2_pkg::DW-1:0]      meas_value,
	input  logic [kf2_pkg::DW-2:0]             meas_variance,
	input  logic signed [kf2_pkg::DW-1:0]      obs_coef_0,
	input  logic signed [kf2_pkg::DW-1:0]      obs_coef_1,
	input  logic [kf2_pkg::DW-1:0]             meas_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [kf2_pkg::DW-1:0]      state_est_0,
	output logic signed [kf2_pkg::DW-1:0]      state_est_1,
	output logic signed [kf2_pkg::DW-1:0]      cov_00,
	output logic signed [kf2_pkg::DW-1:0]      cov_01,
	output logic signed [kf2_pkg::DW-1:0]      cov_10,
	output logic signed [kf2_pkg::DW-1:0]      cov_11,
	output logic                               pose_valid,
	output logic signed [kf2_pkg::DW-1:0]      prev_est_0,
	output logic signed [kf2_pkg::DW-1:0]      prev_est_1,
	output logic [kf2_pkg::DW-1:0]             prev_time,
	output logic                               div_error,
	input  logic                               cfg_we,
	input  logic [kf2_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kf2_pkg::DW-1:0]             cfg_data
);
	import kf2_pkg::*;

	// Commands go from the sequencer to the datapath, status comes back.
	cmd_t cmd;
	sts_t sts;

	kf2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	kf2_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.meas_value    (meas_value),
		.meas_variance (meas_variance),
		.obs_coef_0    (obs_coef_0),
		.obs_coef_1    (obs_coef_1),
		.meas_time     (meas_time),
		.state_est_0   (state_est_0),
		.state_est_1   (state_est_1),
		.cov_00        (cov_00),
		.cov_01        (cov_01),
		.cov_10        (cov_10),
		.cov_11        (cov_11),
		.pose_valid    (pose_valid),
		.prev_est_0    (prev_est_0),
		.prev_est_1    (prev_est_1),
		.prev_time     (prev_time),
		.div_error     (div_error)
	);

endmodule

// ===== hw/rtl/kf2_div.sv =====
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module kf2_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [kf2_pkg::DW-1:0] num0,
	input  logic signed [kf2_pkg::DW-1:0] num1,
	input  logic signed [kf2_pkg::DW-1:0] den,
	output logic                        done,
	output logic signed [kf2_pkg::DW-1:0] quo0,
	output logic signed [kf2_pkg::DW-1:0] quo1
);
	import kf2_pkg::*;

	localparam logic [DVD_W-1:0] LIM_POS = {{FRAC_BITS{1'b0}}, 1'b0, {(DW-1){1'b1}}};
	localparam logic [DVD_W-1:0] LIM_NEG = LIM_POS + 1'b1;

	logic              busy_q, done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DW-1:0]     den_q;
	logic [DW-1:0]     rem_q [2];
	logic [DVD_W-1:0]  dvd_q [2];
	logic [DVD_W-1:0]  quo_q [2];
	logic              neg_q [2];
	logic [DW:0]       trial [2];
	logic              ge    [2];
	logic [DW-1:0]     rem_nx[2];

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
		return a[DW-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic signed [DW-1:0] finish_q(input logic [DVD_W-1:0] q, input logic n);
		logic signed [DW-1:0] r;
		if (n) r = (q > LIM_NEG) ? S_MIN : (~q[DW-1:0] + 1'b1);
		else r = (q > LIM_POS) ? S_MAX : q[DW-1:0];
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i] = {rem_q[i], dvd_q[i][DVD_W-1]};
			ge[i] = trial[i] >= {1'b0, den_q};
			rem_nx[i] = ge[i] ? DW'(trial[i] - {1'b0, den_q}) : trial[i][DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= mag(den);
			dvd_q[0] <= {mag(num0), {FRAC_BITS{1'b0}}};
			dvd_q[1] <= {mag(num1), {FRAC_BITS{1'b0}}};
			neg_q[0] <= num0[DW-1] ^ den[DW-1];
			neg_q[1] <= num1[DW-1] ^ den[DW-1];
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= rem_nx[i];
				dvd_q[i] <= {dvd_q[i][DVD_W-2:0], 1'b0};
				quo_q[i] <= {quo_q[i][DVD_W-2:0], ge[i]};
			end
		end
	end

	assign done = done_q;
	assign quo0 = finish_q(quo_q[0], neg_q[0]);
	assign quo1 = finish_q(quo_q[1], neg_q[1]);

endmodule

// ===== hw/rtl/kf2_datapath.sv =====
// Filter datapath: state, working registers, shared multiply-accumulate and result registers.
module kf2_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kf2_pkg::cmd_t                      cmd,
	output kf2_pkg::sts_t                      sts,
	input  logic                               cfg_we,
	input  logic [kf2_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kf2_pkg::DW-1:0]             cfg_data,
	input  logic                               opcode,
	input  logic signed [kf2_pkg::DW-1:0]      meas_value,
	input  logic [kf2_pkg::DW-2:0]             meas_variance,
	input  logic signed [kf2_pkg::DW-1:0]      obs_coef_0,
	input  logic signed [kf2_pkg::DW-1:0]      obs_coef_1,
	input  logic [kf2_pkg::DW-1:0]             meas_time,
	output logic signed [kf2_pkg::DW-1:0]      state_est_0,
	output logic signed [kf2_pkg::DW-1:0]      state_est_1,
	output logic signed [kf2_pkg::DW-1:0]      cov_00,
	output logic signed [kf2_pkg::DW-1:0]      cov_01,
	output logic signed [kf2_pkg::DW-1:0]      cov_10,
	output logic signed [kf2_pkg::DW-1:0]      cov_11,
	output logic                               pose_valid,
	output logic signed [kf2_pkg::DW-1:0]      prev_est_0,
	output logic signed [kf2_pkg::DW-1:0]      prev_est_1,
	output logic [kf2_pkg::DW-1:0]             prev_time,
	output logic                               div_error
);
	import kf2_pkg::*;

	// Filter state and configuration.
	logic signed [DW-1:0] q_q [4];
	logic signed [DW-1:0] x_q [2];
	logic signed [DW-1:0] p_q [4];
	logic [DW-1:0]        last_q;
	logic                 seen_q;

	// Working registers of one beat.
	logic signed [DW-1:0] z_q, c0_q, c1_q, s_q, tm_q, e_q;
	logic [DW-2:0]        r_q;
	logic [DW-1:0]        t_q;
	logic                 op_q, newer_q, pose_q, derr_q;
	logic signed [DW-1:0] pp_q [4];
	logic signed [DW-1:0] u_q [2];
	logic signed [DW-1:0] v_q [2];
	logic signed [DW-1:0] k_q [2];
	logic signed [DW-1:0] px0_q, px1_q;
	logic [DW-1:0]        pt_q;

	// Multiply-accumulate pipeline.
	logic signed [DW-1:0]    op_a, op_b, op_init;
	logic signed [2*DW-1:0]  prod_s1;
	logic signed [DW-1:0]    init_s1;
	logic                    ien_s1, neg_s1;
	dst_t                    dst_s1;
	logic signed [ACC_W-1:0] acc_q, base, m_ext, acc_nx;
	logic signed [DW-1:0]    wval;

	logic                 div_done;
	logic signed [DW-1:0] div_q0, div_q1;

	function automatic logic signed [DW-1:0] pick(input src_t s);
		logic signed [DW-1:0] v;
		unique case (s)
			SRC_ZERO: v = '0;
			SRC_ONE:  v = FX_ONE;
			SRC_QN0:  v = newer_q ? q_q[0] : '0;
			SRC_QN1:  v = newer_q ? q_q[1] : '0;
			SRC_QN2:  v = newer_q ? q_q[2] : '0;
			SRC_QN3:  v = newer_q ? q_q[3] : '0;
			SRC_P0:   v = p_q[0];
			SRC_P1:   v = p_q[1];
			SRC_P2:   v = p_q[2];
			SRC_P3:   v = p_q[3];
			SRC_PP0:  v = pp_q[0];
			SRC_PP1:  v = pp_q[1];
			SRC_PP2:  v = pp_q[2];
			SRC_PP3:  v = pp_q[3];
			SRC_U0:   v = u_q[0];
			SRC_U1:   v = u_q[1];
			SRC_V0:   v = v_q[0];
			SRC_V1:   v = v_q[1];
			SRC_K0:   v = k_q[0];
			SRC_K1:   v = k_q[1];
			SRC_TM:   v = tm_q;
			SRC_E:    v = e_q;
			SRC_C0:   v = c0_q;
			SRC_C1:   v = c1_q;
			SRC_X0:   v = x_q[0];
			SRC_X1:   v = x_q[1];
			SRC_Z:    v = z_q;
			SRC_R:    v = $signed({1'b0, r_q});
			default:  v = '0;
		endcase
		return v;
	endfunction

	assign op_a    = pick(cmd.uop.a);
	assign op_b    = pick(cmd.uop.b);
	assign op_init = pick(cmd.uop.init_src);

	always_comb begin
		m_ext  = ACC_W'(sat_prod(prod_s1));
		base   = ien_s1 ? ACC_W'(init_s1) : acc_q;
		acc_nx = neg_s1 ? (base - m_ext) : (base + m_ext);
		wval   = sat_acc(acc_nx);
	end

	kf2_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num0   (v_q[0]),
		.num1   (v_q[1]),
		.den    (s_q),
		.done   (div_done),
		.quo0   (div_q0),
		.quo1   (div_q1)
	);

	assign sts.s_zero   = (s_q == '0);
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				q_q[i] <= '0;
				p_q[i] <= '0;
			end
			x_q[0] <= '0;
			x_q[1] <= '0;
			last_q <= '0;
			seen_q <= 1'b0;
			dst_s1 <= DST_NONE;
		end else begin
			dst_s1 <= cmd.uop.dst;
			if (cfg_we) q_q[cfg_index] <= cfg_data;
			if (cmd.clear_state) begin
				for (int i = 0; i < 4; i++) p_q[i] <= '0;
				x_q[0] <= '0;
				x_q[1] <= '0;
				last_q <= '0;
				seen_q <= 1'b0;
			end else begin
				unique case (dst_s1)
					DST_X0:  x_q[0] <= wval;
					DST_X1:  x_q[1] <= wval;
					DST_P0:  p_q[0] <= wval;
					DST_P1:  p_q[1] <= wval;
					DST_P2:  p_q[2] <= wval;
					DST_P3:  p_q[3] <= wval;
					default: ;
				endcase
				if (cmd.finish && op_q == OP_MEAS && !derr_q) begin
					last_q <= t_q;
					seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		init_s1 <= op_init;
		ien_s1  <= cmd.uop.init_en;
		neg_s1  <= cmd.uop.neg;
		acc_q   <= acc_nx;

		if (cmd.capture) begin
			op_q    <= opcode;
			z_q     <= meas_value;
			r_q     <= meas_variance;
			c0_q    <= obs_coef_0;
			c1_q    <= obs_coef_1;
			t_q     <= meas_time;
			newer_q <= !seen_q || (meas_time > last_q);
			pose_q  <= (opcode == OP_MEAS) && seen_q && (meas_time > last_q);
			derr_q  <= 1'b0;
			px0_q   <= x_q[0];
			px1_q   <= x_q[1];
			pt_q    <= last_q;
		end
		if (cmd.set_derr) derr_q <= 1'b1;
		if (div_done) begin
			k_q[0] <= div_q0;
			k_q[1] <= div_q1;
		end

		unique case (dst_s1)
			DST_PP0: pp_q[0] <= wval;
			DST_PP1: pp_q[1] <= wval;
			DST_PP2: pp_q[2] <= wval;
			DST_PP3: pp_q[3] <= wval;
			DST_U0:  u_q[0] <= wval;
			DST_U1:  u_q[1] <= wval;
			DST_V0:  v_q[0] <= wval;
			DST_V1:  v_q[1] <= wval;
			DST_S:   s_q <= wval;
			DST_TM:  tm_q <= wval;
			DST_E:   e_q <= wval;
			default: ;
		endcase

		if (cmd.finish) begin
			state_est_0 <= x_q[0];
			state_est_1 <= x_q[1];
			cov_00      <= p_q[0];
			cov_01      <= p_q[1];
			cov_10      <= p_q[2];
			cov_11      <= p_q[3];
			pose_valid  <= pose_q;
			prev_est_0  <= px0_q;
			prev_est_1  <= px1_q;
			prev_time   <= pt_q;
			div_error   <= derr_q;
		end
	end

endmodule

// ===== hw/rtl/kf2_ctrl.sv =====
// Sequencer of the filter: walks the operation list, runs the divider and hands over results.
module kf2_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          opcode,
	input  logic          out_ready,
	output logic          in_ready,
	output logic          out_valid,
	output kf2_pkg::cmd_t cmd,
	input  kf2_pkg::sts_t sts
);
	import kf2_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_RUN, ST_CHECK, ST_DIV, ST_FINISH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.uop = UOP_NOP;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_CLEAR:  cmd.clear_state = 1'b1;
			ST_RUN:    cmd.uop = ucode(step_q);
			ST_CHECK: begin
				cmd.set_derr  = sts.s_zero;
				cmd.div_start = !sts.s_zero;
			end
			ST_FINISH: cmd.finish = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one that leaves in the same cycle.
			if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q <= '0;
						state_q <= (opcode == OP_RESET) ? ST_CLEAR : ST_RUN;
					end
				end
				ST_CLEAR: state_q <= ST_FINISH;
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_PRE_LAST) state_q <= ST_CHECK;
					else if (step_q == STEP_LAST) state_q <= ST_FINISH;
				end
				ST_CHECK: state_q <= sts.s_zero ? ST_FINISH : ST_DIV;
				ST_DIV: begin
					if (sts.div_done) state_q <= ST_RUN;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_zero_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && sts.s_zero) |=> (state_q == ST_FINISH))
		else $error("zero innovation variance did not go straight to finish");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= STEP_LAST))
		else $error("operation step ran past the end of the list");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("waiting result beat was dropped");

endmodule
